[rtl/core/nonoverlap_substring_search_unit_assert.svh]
// Assertion macros for the nonoverlap substring search unit checker.
// Depends on a clk_i clock and an active-low rst_ni reset in the using scope.
`ifndef NONOVERLAP_SUBSTRING_SEARCH_UNIT_ASSERT_SVH
`define NONOVERLAP_SUBSTRING_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NSSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NSSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/nssu_pkg.sv]
// Shared constants, types and helpers for the nonoverlap substring search unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nssu_pkg;

  localparam int MAX_NEEDLE    = 16;
  localparam int NEEDLE_IDX_W  = $clog2(MAX_NEEDLE);
  localparam int LEN_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int OFFSET_BITS   = 32;
  localparam int MATCH_START_W = 32;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int NEEDLE_W      = MAX_NEEDLE * BYTE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LOW  = 2'd0,
    CFG_NEEDLE_HIGH = 2'd1,
    CFG_NEEDLE_LEN  = 2'd2
  } cfg_idx_e;

  // Per-cycle control shared by every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] needle_byte(
    input logic [NEEDLE_W-1:0]     needle,
    input logic [NEEDLE_IDX_W-1:0] idx
  );
    needle_byte = needle[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

[rtl/core/nonoverlap_substring_search_unit.sv]
// Each byte transfer loads its result into the output register.
// Throughput: one byte per cycle; a byte is taken while a result waits, as long as
// the output register is free or drains in the same cycle.
// Match detection is one compare per window cell plus an AND across the cell row.
// Reset: window, byte offset and hit distance clear; needle zero, length one.
`timescale 1ns / 1ps
`default_nettype none

module nonoverlap_substring_search_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [nssu_pkg::BYTE_W-1:0]          data_byte_i,
  input  logic                                last_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [nssu_pkg::MATCH_START_W-1:0]   match_start_o,
  output logic                                buffer_end_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nssu_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [nssu_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import nssu_pkg::*;

  // Configuration
  logic [CFG_DATA_W-1:0] needle_lo_q, needle_hi_q;
  logic [LEN_W-1:0]      len_q;
  logic [NEEDLE_W-1:0]   needle;

  assign cfg_ready_o = 1'b1;
  assign needle      = {needle_hi_q[NEEDLE_W/2-1:0], needle_lo_q[NEEDLE_W/2-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_lo_q <= '0;
      needle_hi_q <= '0;
      len_q       <= LEN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NEEDLE_LOW:  needle_lo_q <= cfg_data_i;
        CFG_NEEDLE_HIGH: needle_hi_q <= cfg_data_i;
        CFG_NEEDLE_LEN:  len_q       <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Window cell row
  cell_ctrl_t            cell_ctrl;
  logic [BYTE_W-1:0]     window [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] cell_match;

  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && last_byte_i;

  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
    logic [BYTE_W-1:0]       cell_in;
    logic                    used;
    logic [NEEDLE_IDX_W-1:0] idx;

    if (k == 0) begin : g_head
      assign cell_in = data_byte_i;
    end else begin : g_link
      assign cell_in = window[k-1];
    end

    // Cell k sees the byte that sits len-1-k places into the needle.
    assign used = LEN_W'(k) < len_q;
    assign idx  = NEEDLE_IDX_W'(len_q - LEN_W'(k) - LEN_W'(1));

    nssu_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .byte_i   (cell_in),
      .expect_i (needle_byte(needle, idx)),
      .used_i   (used),
      .byte_o   (window[k]),
      .match_o  (cell_match[k])
    );
  end

  // Offset and distance since the last hit
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [LEN_W-1:0]       since_q, since_d;
  logic [LEN_W-1:0]       seen;
  logic                   len_ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;

  assign seen   = (since_q >= LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : since_q + LEN_W'(1);
  assign len_ok = (len_q != '0) && (len_q <= LEN_W'(MAX_NEEDLE));
  assign hit    = len_ok && (seen >= len_q) && (&cell_match);
  assign start  = hit ? offset_q - OFFSET_BITS'(len_q - LEN_W'(1)) : '0;

  always_comb begin
    offset_d = offset_q;
    since_d  = since_q;
    if (accept) begin
      if (last_byte_i) begin
        offset_d = '0;
        since_d  = '0;
      end else begin
        if (offset_q != '1) begin
          offset_d = offset_q + OFFSET_BITS'(1);
        end
        since_d = hit ? '0 : seen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      since_q  <= '0;
    end else begin
      offset_q <= offset_d;
      since_q  <= since_d;
    end
  end

  // Output register
  logic                     hit_q, end_q;
  logic [MATCH_START_W-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q   <= hit;
      start_q <= MATCH_START_W'(start);
      end_q   <= last_byte_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign match_start_o = start_q;
  assign buffer_end_o  = end_q;

endmodule

`default_nettype wire

[rtl/core/nssu_cell.sv]
// One window cell: holds one buffer byte and compares the byte moving into it.
// Depends on nssu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nssu_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nssu_pkg::cell_ctrl_t       ctrl_i,
  input  logic [nssu_pkg::BYTE_W-1:0] byte_i,
  input  logic [nssu_pkg::BYTE_W-1:0] expect_i,
  input  logic                       used_i,
  output logic [nssu_pkg::BYTE_W-1:0] byte_o,
  output logic                       match_o
);
  import nssu_pkg::*;

  logic [BYTE_W-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // Compare the byte that lands here on this transfer; unused cells always agree.
  assign match_o = !used_i || (byte_i == expect_i);
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

[rtl/core/nssu_checker.sv]
// Port-level checker for the nonoverlap substring search unit, bound to the top level.
// Depends on nssu_pkg and nonoverlap_substring_search_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "nonoverlap_substring_search_unit_assert.svh"

module nssu_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic                                hit_o,
  input  logic [nssu_pkg::MATCH_START_W-1:0]   match_start_o,
  input  logic                                buffer_end_o
);
  import nssu_pkg::*;

  logic                     in_xfer;
  logic                     out_held;
  logic [MATCH_START_W+1:0] out_word;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {hit_o, match_start_o, buffer_end_o};

  // Every input transfer shows up as a result on the next cycle.
  `NSSU_ASSERT_NEXT(a_result_follows, in_xfer, out_valid_o, "no result after byte transfer")

  // The input side only stalls behind a held result.
  `NSSU_ASSERT_IMP(a_stall_cause, in_stall_o, out_held, "stall without held result")

  // A miss carries no match offset.
  `NSSU_ASSERT_IMP(a_miss_zero, out_valid_o && !hit_o, match_start_o == '0, "offset on a miss")

  // A stalled result holds.
  `NSSU_ASSERT_NEXT(a_hold, out_held, out_valid_o && $stable(out_word), "stalled result changed")

endmodule

bind nonoverlap_substring_search_unit nssu_checker u_nssu_checker (.*);

`default_nettype wire
